### design/contactor_precharge_sequencer_top_defines.svh
// assertion helpers for the sequencer top
`ifndef CONTACTOR_PRECHARGE_SEQUENCER_TOP_DEFINES_SVH
`define CONTACTOR_PRECHARGE_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication
`define CPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/cps_pkg.sv
package cps_pkg;

  localparam int VOLTAGE_BITS = 16;
  localparam int RATIO_BITS   = 16;
  localparam int PROD_BITS    = RATIO_BITS + VOLTAGE_BITS;
  localparam int STEP_BITS    = 5;

  localparam logic [RATIO_BITS-1:0] RATIO_RESET = 16'd58982;

  // configuration register indexes
  localparam logic CFG_DRIVE_RATIO  = 1'b0;
  localparam logic CFG_CHARGE_RATIO = 1'b1;

  // vehicle request codes
  localparam logic [2:0] REQ_IDLE      = 3'd0;
  localparam logic [2:0] REQ_PRECHARGE = 3'd1;
  localparam logic [2:0] REQ_FAULT     = 3'd4;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_PRECHARGE = 3'd1,
    MODE_ACTIVE    = 3'd2,
    MODE_FAULT     = 3'd3,
    MODE_CHARGING  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    PHASE_SETUP     = 2'd0,
    PHASE_PRECHARGE = 2'd1,
    PHASE_ACTIVE    = 2'd2
  } phase_e;

  // contactor patterns {negative, positive, precharge}
  localparam logic [2:0] CONT_OPEN = 3'b000;
  localparam logic [2:0] CONT_PRE  = 3'b101;
  localparam logic [2:0] CONT_RUN  = 3'b110;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_OUT_BUSY,
    C_MODE_CHG,
    C_HARD,
    C_EXT,
    C_IDLE_WANT,
    C_REQ_OFF,
    C_REQ_PRE,
    C_MODE_IDLE,
    C_MODE_PRE,
    C_PH_SETUP,
    C_PH_PRE,
    C_CHG_LOST,
    C_RATIO
  } cond_e;

  typedef struct packed {
    logic [2:0]              vehicle_request;
    logic                    battery_fault;
    logic                    insulation_ok;
    logic                    outside_fault;
    logic                    charger_lost;
    logic                    enter_charging;
    logic [VOLTAGE_BITS-1:0] inverter_voltage;
    logic [VOLTAGE_BITS-1:0] chg_out_voltage;
    logic [VOLTAGE_BITS-1:0] pack_voltage;
  } in_t;

  typedef struct packed {
    logic       negative_contactor;
    logic       positive_contactor;
    logic       precharge_contactor;
    logic [2:0] mode_now;
    logic [1:0] charge_phase;
  } out_t;

  // datapath actions of one control word
  typedef struct packed {
    logic       accept;
    logic       emit;
    logic       mul_en;
    logic       mul_chg;
    logic       mode_we;
    mode_e      mode;
    logic       phase_we;
    phase_e     phase;
    logic       cont_we;
    logic [2:0] cont;
  } ctrl_t;

  typedef struct packed {
    cond_e                cond;
    logic                 inv;
    logic [STEP_BITS-1:0] target;
    ctrl_t                act;
  } uword_t;

  // status flags back to the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic mode_chg;
    logic hard;
    logic ext;
    logic idle_want;
    logic req_off;
    logic req_pre;
    logic mode_idle;
    logic mode_pre;
    logic ph_setup;
    logic ph_pre;
    logic chg_lost;
    logic ratio;
  } flags_t;

  // program addresses
  localparam logic [STEP_BITS-1:0] U_FETCH     = 5'd0;
  localparam logic [STEP_BITS-1:0] U_DISPATCH  = 5'd1;
  localparam logic [STEP_BITS-1:0] U_HARD      = 5'd2;
  localparam logic [STEP_BITS-1:0] U_EXT       = 5'd3;
  localparam logic [STEP_BITS-1:0] U_WANT      = 5'd4;
  localparam logic [STEP_BITS-1:0] U_REQOFF    = 5'd5;
  localparam logic [STEP_BITS-1:0] U_REQPRE    = 5'd6;
  localparam logic [STEP_BITS-1:0] U_ISIDLE    = 5'd7;
  localparam logic [STEP_BITS-1:0] U_DMUL      = 5'd8;
  localparam logic [STEP_BITS-1:0] U_DCMP      = 5'd9;
  localparam logic [STEP_BITS-1:0] U_DRUN      = 5'd10;
  localparam logic [STEP_BITS-1:0] U_CHG       = 5'd11;
  localparam logic [STEP_BITS-1:0] U_CLOSTCHK  = 5'd12;
  localparam logic [STEP_BITS-1:0] U_CSETCHK   = 5'd13;
  localparam logic [STEP_BITS-1:0] U_CMUL      = 5'd14;
  localparam logic [STEP_BITS-1:0] U_CCMP      = 5'd15;
  localparam logic [STEP_BITS-1:0] U_CRUN      = 5'd16;
  localparam logic [STEP_BITS-1:0] U_CSETUP    = 5'd17;
  localparam logic [STEP_BITS-1:0] U_CLOST     = 5'd18;
  localparam logic [STEP_BITS-1:0] U_FAULT     = 5'd19;
  localparam logic [STEP_BITS-1:0] U_OFF       = 5'd20;
  localparam logic [STEP_BITS-1:0] U_ENTCHG    = 5'd21;
  localparam logic [STEP_BITS-1:0] U_PRESTART  = 5'd22;
  localparam logic [STEP_BITS-1:0] U_EMIT      = 5'd23;
  localparam logic [STEP_BITS-1:0] U_RETURN    = 5'd24;

  // control store: jump to target when (cond ^ inv), else fall through
  function automatic uword_t ucode(input logic [STEP_BITS-1:0] addr);
    uword_t w;
    w            = '0;
    w.cond       = C_ALWAYS;
    w.inv        = 1'b1;
    w.target     = U_FETCH;
    w.act.mode   = MODE_IDLE;
    w.act.phase  = PHASE_SETUP;
    unique case (addr)
      U_FETCH: begin
        w.cond = C_IN_VALID; w.target = U_FETCH; w.act.accept = 1'b1;
      end
      U_DISPATCH: begin w.cond = C_MODE_CHG; w.inv = 1'b0; w.target = U_CHG; end
      U_HARD:     begin w.cond = C_HARD; w.inv = 1'b0; w.target = U_FAULT; end
      U_EXT:      begin w.cond = C_EXT; w.inv = 1'b0; w.target = U_OFF; end
      U_WANT:     begin w.cond = C_IDLE_WANT; w.inv = 1'b0; w.target = U_ENTCHG; end
      U_REQOFF:   begin w.cond = C_REQ_OFF; w.inv = 1'b0; w.target = U_OFF; end
      U_REQPRE:   begin w.cond = C_REQ_PRE; w.target = U_EMIT; end
      U_ISIDLE:   begin w.cond = C_MODE_IDLE; w.inv = 1'b0; w.target = U_PRESTART; end
      U_DMUL: begin
        w.cond = C_MODE_PRE; w.target = U_EMIT; w.act.mul_en = 1'b1;
      end
      U_DCMP:     begin w.cond = C_RATIO; w.target = U_EMIT; end
      U_DRUN: begin
        w.inv = 1'b0; w.target = U_EMIT;
        w.act.cont_we = 1'b1; w.act.cont = CONT_RUN;
        w.act.mode_we = 1'b1; w.act.mode = MODE_ACTIVE;
      end
      U_CHG:      begin w.cond = C_HARD; w.inv = 1'b0; w.target = U_FAULT; end
      U_CLOSTCHK: begin w.cond = C_CHG_LOST; w.inv = 1'b0; w.target = U_CLOST; end
      U_CSETCHK:  begin w.cond = C_PH_SETUP; w.inv = 1'b0; w.target = U_CSETUP; end
      U_CMUL: begin
        w.cond = C_PH_PRE; w.target = U_EMIT;
        w.act.mul_en = 1'b1; w.act.mul_chg = 1'b1;
      end
      U_CCMP:     begin w.cond = C_RATIO; w.target = U_EMIT; end
      U_CRUN: begin
        w.inv = 1'b0; w.target = U_EMIT;
        w.act.cont_we = 1'b1; w.act.cont = CONT_RUN;
        w.act.phase_we = 1'b1; w.act.phase = PHASE_ACTIVE;
      end
      U_CSETUP: begin
        w.inv = 1'b0; w.target = U_EMIT;
        w.act.cont_we = 1'b1; w.act.cont = CONT_PRE;
        w.act.phase_we = 1'b1; w.act.phase = PHASE_PRECHARGE;
      end
      U_CLOST: begin
        w.inv = 1'b0; w.target = U_EMIT;
        w.act.cont_we = 1'b1; w.act.cont = CONT_OPEN;
        w.act.mode_we = 1'b1; w.act.mode = MODE_IDLE;
        w.act.phase_we = 1'b1; w.act.phase = PHASE_SETUP;
      end
      U_FAULT: begin
        w.inv = 1'b0; w.target = U_EMIT;
        w.act.cont_we = 1'b1; w.act.cont = CONT_OPEN;
        w.act.mode_we = 1'b1; w.act.mode = MODE_FAULT;
      end
      U_OFF: begin
        w.inv = 1'b0; w.target = U_EMIT;
        w.act.cont_we = 1'b1; w.act.cont = CONT_OPEN;
        w.act.mode_we = 1'b1; w.act.mode = MODE_IDLE;
      end
      U_ENTCHG: begin
        w.inv = 1'b0; w.target = U_EMIT;
        w.act.mode_we = 1'b1; w.act.mode = MODE_CHARGING;
        w.act.phase_we = 1'b1; w.act.phase = PHASE_SETUP;
      end
      U_PRESTART: begin
        w.inv = 1'b0; w.target = U_EMIT;
        w.act.cont_we = 1'b1; w.act.cont = CONT_PRE;
        w.act.mode_we = 1'b1; w.act.mode = MODE_PRECHARGE;
      end
      U_EMIT: begin
        w.cond = C_OUT_BUSY; w.inv = 1'b0; w.target = U_EMIT; w.act.emit = 1'b1;
      end
      U_RETURN:   begin w.inv = 1'b0; w.target = U_FETCH; end
      default:    begin w.inv = 1'b0; w.target = U_FETCH; end
    endcase
    return w;
  endfunction

endpackage

### design/cps_useq.sv
module cps_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cps_pkg::flags_t flags_i,
  output cps_pkg::ctrl_t  ctrl_o
);
  import cps_pkg::*;

  logic [STEP_BITS-1:0] step_q, step_d;
  uword_t               word;
  logic                 cond_hit;

  assign word   = ucode(step_q);
  assign ctrl_o = word.act;

  always_comb begin
    unique case (word.cond)
      C_ALWAYS:    cond_hit = 1'b1;
      C_IN_VALID:  cond_hit = flags_i.in_valid;
      C_OUT_BUSY:  cond_hit = flags_i.out_busy;
      C_MODE_CHG:  cond_hit = flags_i.mode_chg;
      C_HARD:      cond_hit = flags_i.hard;
      C_EXT:       cond_hit = flags_i.ext;
      C_IDLE_WANT: cond_hit = flags_i.idle_want;
      C_REQ_OFF:   cond_hit = flags_i.req_off;
      C_REQ_PRE:   cond_hit = flags_i.req_pre;
      C_MODE_IDLE: cond_hit = flags_i.mode_idle;
      C_MODE_PRE:  cond_hit = flags_i.mode_pre;
      C_PH_SETUP:  cond_hit = flags_i.ph_setup;
      C_PH_PRE:    cond_hit = flags_i.ph_pre;
      C_CHG_LOST:  cond_hit = flags_i.chg_lost;
      C_RATIO:     cond_hit = flags_i.ratio;
      default:     cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_hit ^ word.inv) begin
      step_d = word.target;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= U_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

### design/cps_dpath.sv
module cps_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [cps_pkg::RATIO_BITS-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  input  cps_pkg::in_t                     in_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output cps_pkg::out_t                    out_o,
  input  cps_pkg::ctrl_t                   ctrl_i,
  output cps_pkg::flags_t                  flags_o
);
  import cps_pkg::*;

  logic [RATIO_BITS-1:0] drive_ratio_q, charge_ratio_q;
  in_t                   in_q;
  mode_e                 mode_q, mode_d;
  phase_e                phase_q, phase_d;
  logic [2:0]            cont_q, cont_d;
  logic [PROD_BITS-1:0]  prod_q, vshift_q;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q;
  logic                  out_busy, emit_fire, hard;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_ratio_q  <= RATIO_RESET;
      charge_ratio_q <= RATIO_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DRIVE_RATIO:  drive_ratio_q  <= cfg_data_i;
        CFG_CHARGE_RATIO: charge_ratio_q <= cfg_data_i;
        default:          drive_ratio_q  <= drive_ratio_q;
      endcase
    end
  end

  // input latch
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept && in_valid_i) begin
      in_q <= in_i;
    end
  end

  // ratio test: v * 2^16 against ratio * pack
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      if (ctrl_i.mul_chg) begin
        prod_q   <= charge_ratio_q * in_q.pack_voltage;
        vshift_q <= {in_q.chg_out_voltage, {RATIO_BITS{1'b0}}};
      end else begin
        prod_q   <= drive_ratio_q * in_q.pack_voltage;
        vshift_q <= {in_q.inverter_voltage, {RATIO_BITS{1'b0}}};
      end
    end
  end

  // sequencer state
  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    cont_d  = cont_q;
    if (ctrl_i.mode_we) begin
      mode_d = ctrl_i.mode;
    end
    if (ctrl_i.phase_we) begin
      phase_d = ctrl_i.phase;
    end
    if (ctrl_i.cont_we) begin
      cont_d = ctrl_i.cont;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      phase_q <= PHASE_SETUP;
      cont_q  <= CONT_OPEN;
    end else begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      cont_q  <= cont_d;
    end
  end

  // output register
  assign out_busy  = out_valid_q && !out_ready_i;
  assign emit_fire = ctrl_i.emit && !out_busy;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_q.negative_contactor  <= cont_q[2];
      out_q.positive_contactor  <= cont_q[1];
      out_q.precharge_contactor <= cont_q[0];
      out_q.mode_now            <= mode_q;
      out_q.charge_phase        <= phase_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // condition flags
  assign hard = (mode_q == MODE_FAULT) || in_q.battery_fault || !in_q.insulation_ok;

  always_comb begin
    flags_o.in_valid  = in_valid_i;
    flags_o.out_busy  = out_busy;
    flags_o.mode_chg  = (mode_q == MODE_CHARGING);
    flags_o.hard      = hard;
    flags_o.ext       = in_q.outside_fault;
    flags_o.idle_want = (mode_q == MODE_IDLE) && in_q.enter_charging;
    flags_o.req_off   = (in_q.vehicle_request == REQ_IDLE) ||
                        (in_q.vehicle_request == REQ_FAULT);
    flags_o.req_pre   = (in_q.vehicle_request == REQ_PRECHARGE);
    flags_o.mode_idle = (mode_q == MODE_IDLE);
    flags_o.mode_pre  = (mode_q == MODE_PRECHARGE);
    flags_o.ph_setup  = (phase_q == PHASE_SETUP);
    flags_o.ph_pre    = (phase_q == PHASE_PRECHARGE);
    flags_o.chg_lost  = in_q.charger_lost;
    flags_o.ratio     = vshift_q > prod_q;
  end

endmodule

### design/contactor_precharge_sequencer_top.sv
// Contactor precharge sequencer. Each input transaction is one control tick
// (vehicle request, fault flags, charger timeout, three voltages) and yields
// exactly one output transaction with the three contactor commands, the main
// mode and the charging phase after the update. A battery fault or a failing
// insulation monitor latches fault mode until reset; outside charging mode an
// outside fault opens everything and returns to idle. Precharge ends when
// v * 65536 exceeds ratio * pack, with the thresholds written through the cfg
// port (index 0 drive, index 1 charge, both reset to 58982). Control comes
// from a small microprogram in a constant control store that walks the
// decision chain one test per clock, while the emit step waits as long as the
// output register is full; the drive precharge compare is the longest path
// (one multiply step, one compare step). One transaction is in flight at a
// time; after the result is loaded into the output register the sequencer
// passes through the return step back to fetch, even if the consumer has not
// yet picked it up.
`include "contactor_precharge_sequencer_top_defines.svh"

module contactor_precharge_sequencer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [cps_pkg::RATIO_BITS-1:0] cfg_data_i,
  // tick input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  cps_pkg::in_t                   in_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output cps_pkg::out_t                  out_o
);
  import cps_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;

  // step counter plus control store
  cps_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  // state registers, ratio multiplier, output register
  cps_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .ctrl_i      (ctrl),
    .flags_o     (flags)
  );

  // only the fetch step takes a transaction
  assign in_ready_o = ctrl.accept;

  // fetch is left right after a transaction is taken
  `CPS_ASSERT_NEXT(a_fetch_leaves, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o,
                   "sequencer stayed in fetch after accepting a transaction")

  // positive and precharge contactors never closed together
  `CPS_ASSERT_NOW(a_no_double_close, clk_i, rst_ni, out_valid_o,
                  !(out_o.positive_contactor && out_o.precharge_contactor),
                  "positive and precharge contactors closed together")

  // fault mode reports every contactor open
  `CPS_ASSERT_NOW(a_fault_open, clk_i, rst_ni,
                  out_valid_o && (out_o.mode_now == MODE_FAULT),
                  !out_o.negative_contactor && !out_o.positive_contactor &&
                  !out_o.precharge_contactor,
                  "contactor closed in fault mode")

endmodule
